/* src/bsls_pkg.sv */
// Shared types, constants and register codes for the bouncing segment LED scanner.
// No dependencies; every other file in the project imports this package.
package bsls_pkg;

	// Position format: unsigned fixed point, POS_FRAC_BITS fraction bits, 1.0 = POS_ONE.
	localparam int POS_FRAC_BITS = 16;
	localparam int POS_W         = POS_FRAC_BITS + 1;
	localparam int DELTA_W       = POS_W + 1;
	localparam int COLOUR_W      = 8;
	localparam int SPEED_W       = 4;
	localparam int ACC_W         = SPEED_W + 1;

	localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << POS_FRAC_BITS;
	// Segment half-width, round(1/6), and head step per two speed units, round(0.015).
	localparam int               SEG_LEN_INT  = ((1 << POS_FRAC_BITS) + 3) / 6;
	localparam int               STEP_INT     = ((1 << POS_FRAC_BITS) * 15 + 500) / 1000;
	localparam logic [POS_W-1:0] SEG_LEN      = POS_W'(SEG_LEN_INT);
	localparam logic [DELTA_W-1:0] STEP_SIZE  = DELTA_W'(STEP_INT);

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Item mode codes.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Configuration register indexes.
	localparam int             CFG_IDX_W   = 2;
	localparam int             CFG_DATA_W  = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [16:0] pixel_x;
	} in_item_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} out_item_t;

	// A classified item as it travels through the queue.
	typedef struct packed {
		logic             is_tick;
		logic [POS_W-1:0] x;
	} qentry_t;

endpackage

/* src/bsls_front.sv */
// Front part: accepts input beats and classifies them into queue entries.
// Depends on bsls_pkg.
module bsls_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bsls_pkg::in_item_t in_data,
	output logic              ent_valid,
	output bsls_pkg::qentry_t ent_data,
	input  logic              ent_stall
);
	import bsls_pkg::*;

	logic    valid_q;
	qentry_t ent_q;
	logic    load;

	// The holding register frees up whenever the queue takes its entry.
	assign in_stall = valid_q & ent_stall;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q.is_tick <= (in_data.mode == MODE_TICK);
			ent_q.x       <= in_data.pixel_x[POS_W-1:0];
		end
	end

	assign ent_valid = valid_q;
	assign ent_data  = ent_q;

endmodule

/* src/bsls_queue.sv */
// Short first-in first-out queue of classified items between front and back.
// Depends on bsls_pkg.
module bsls_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_stall,
	input  bsls_pkg::qentry_t push_data,
	output logic              pop_valid,
	input  logic              pop,
	output bsls_pkg::qentry_t pop_data
);
	import bsls_pkg::*;

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid & ~push_stall;
	assign do_pop     = pop & pop_valid;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(push_stall && !do_pop) |=> push_stall)
		else $error("full queue drained without a pop");

	a_rd_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && QUEUE_DEPTH > 1) |=> (rd_q != $past(rd_q)))
		else $error("read pointer did not advance on pop");

endmodule

/* src/bsls_back.sv */
// Back part: moves the head on ticks and shades pixels, holding the configuration.
// Depends on bsls_pkg.
module bsls_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsls_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bsls_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          ent_valid,
	output logic                          ent_pop,
	input  bsls_pkg::qentry_t             ent_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bsls_pkg::out_item_t           out_data
);
	import bsls_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FACTOR = 2'd1;
	localparam logic [1:0] ST_COLOUR = 2'd2;

	logic [1:0]          state_q;
	logic [COLOUR_W-1:0] red_q, green_q, blue_q;
	logic [SPEED_W-1:0]  speed_q;

	logic [POS_W-1:0]    head_q;
	logic                back_q;
	logic                rem_q;

	logic [POS_W-1:0]    lin_q;
	logic                hit_q;
	logic [POS_W-1:0]    factor_q;

	logic                out_valid_q;
	out_item_t           out_q;

	logic [POS_W:0]      diff;
	logic [POS_W-1:0]    rel;
	logic [POS_W+2:0]    rel_x6;
	logic [POS_W+2:0]    lin_wide;
	logic [2*POS_W-1:0]  lin_sq;
	logic [COLOUR_W+POS_W-1:0] prod_r, prod_g, prod_b;
	logic [ACC_W-1:0]    acc;
	logic [SPEED_W-1:0]  steps;
	logic [DELTA_W-1:0]  delta;
	logic [DELTA_W:0]    sum;
	logic                take_out;
	logic                load_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= COLOUR_W'(255);
			green_q <= '0;
			blue_q  <= '0;
			speed_q <= SPEED_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BASE_RED:   red_q   <= cfg_data;
				CFG_BASE_GREEN: green_q <= cfg_data;
				CFG_BASE_BLUE:  blue_q  <= cfg_data;
				CFG_SPEED:      speed_q <= cfg_data[SPEED_W-1:0];
				default:        ;
			endcase
		end
	end

	// Distance of the pixel from the head and the linear falloff 1 - 6*rel.
	assign diff     = {1'b0, ent_data.x} - {1'b0, head_q};
	assign rel      = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
	assign rel_x6   = {rel, 2'b00} + {1'b0, rel, 1'b0};
	assign lin_wide = (POS_W+3)'(POS_ONE) - rel_x6;

	// Motion: remainder plus speed, whole steps move the head.
	assign acc   = ACC_W'(speed_q) + ACC_W'(rem_q);
	assign steps = acc[ACC_W-1:1];
	assign delta = DELTA_W'(steps) * STEP_SIZE;
	assign sum   = (DELTA_W+1)'(head_q) + (DELTA_W+1)'(delta);

	assign lin_sq = lin_q * lin_q;
	assign prod_r = red_q * factor_q;
	assign prod_g = green_q * factor_q;
	assign prod_b = blue_q * factor_q;

	assign ent_pop  = (state_q == ST_IDLE) & ent_valid;
	assign take_out = out_valid_q & ~out_stall;
	assign load_out = (state_q == ST_COLOUR) & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			back_q  <= 1'b0;
			rem_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ent_valid) begin
						if (ent_data.is_tick) begin
							rem_q <= acc[0];
							if (steps != '0) begin
								if (!back_q) begin
									if (sum >= (DELTA_W+1)'(POS_ONE)) begin
										head_q <= POS_ONE;
										back_q <= 1'b1;
									end else begin
										head_q <= sum[POS_W-1:0];
									end
								end else begin
									if (delta >= DELTA_W'(head_q)) begin
										head_q <= '0;
										back_q <= 1'b0;
									end else begin
										head_q <= head_q - delta[POS_W-1:0];
									end
								end
							end
						end else begin
							state_q <= ST_FACTOR;
						end
					end
				end
				ST_FACTOR: begin
					state_q <= ST_COLOUR;
				end
				ST_COLOUR: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ent_pop && !ent_data.is_tick) begin
			lin_q <= lin_wide[POS_W-1:0];
			hit_q <= (rel < SEG_LEN);
		end
		if (state_q == ST_FACTOR) begin
			factor_q <= lin_sq[POS_FRAC_BITS +: POS_W];
		end
		if (load_out) begin
			if (hit_q) begin
				out_q.red   <= prod_r[POS_FRAC_BITS +: COLOUR_W];
				out_q.green <= prod_g[POS_FRAC_BITS +: COLOUR_W];
				out_q.blue  <= prod_b[POS_FRAC_BITS +: COLOUR_W];
			end else begin
				out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (take_out) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= POS_ONE)
		else $error("head beyond the right end");

	a_turn_right: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(back_q) |-> (head_q == POS_ONE))
		else $error("head turned back away from the right end");

	a_turn_left: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(back_q) |-> (head_q == '0))
		else $error("head turned forward away from the left end");

	a_factor_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FACTOR) |=> (state_q == ST_COLOUR))
		else $error("factor step not followed by colour step");

endmodule

/* src/bouncing_segment_led_scanner_top.sv */
// Top level of the bouncing segment LED scanner: front, queue and back parts.
// Depends on bsls_pkg, bsls_front, bsls_queue and bsls_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | into      | in_valid / in_stall    | in_data  (mode, pixel_x)
//  out     | out of    | out_valid / out_stall  | out_data (red, green, blue)
//  cfg     | into      | cfg_we, no wait        | cfg_idx, cfg_data
//
// A beat on the input is registered by the front part and classified as a tick or a pixel
// before it enters a two-entry queue. The back part takes one entry at a time: a tick is
// retired in the cycle it leaves the queue, a pixel passes through the steps of distance
// and linear falloff, squaring and colour scaling into the output register before the
// next entry is taken. Ticks flow at one per cycle while the back part is idle.
// The output register holds a finished beat while out_stall is high; the back part then
// waits in its colour step, the queue fills and in_stall rises only once the front
// register is also occupied, so the input side keeps running for a few beats.
// Reset (arst_n low) empties every stage, puts the head at the left end moving forward
// and restores the configuration reset values; no clearing pass is needed.
module bouncing_segment_led_scanner_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsls_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bsls_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bsls_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bsls_pkg::out_item_t             out_data
);
	import bsls_pkg::*;

	// Front register to queue.
	logic    fq_valid;
	logic    fq_stall;
	qentry_t fq_data;

	// Queue to back part.
	logic    qb_valid;
	logic    qb_pop;
	qentry_t qb_data;

	bsls_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.ent_valid (fq_valid),
		.ent_data  (fq_data),
		.ent_stall (fq_stall)
	);

	bsls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_stall (fq_stall),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop        (qb_pop),
		.pop_data   (qb_data)
	);

	// The back part owns the head state and the configuration registers, so that
	// a tick and the pixels after it are seen in the order they arrived.
	bsls_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.ent_valid (qb_valid),
		.ent_pop   (qb_pop),
		.ent_data  (qb_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
